/* hdl/pfla_pkg.sv */
package pfla_pkg;

  localparam int unsigned NUM_PAGES  = 1024;
  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned IDX_W      = $clog2(NUM_PAGES + 1);
  localparam int unsigned RAM_AW     = $clog2(NUM_PAGES);
  localparam int unsigned PAGE_NUM_W = DATA_W - PAGE_SHIFT;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [RAM_AW-1:0] ram_addr_t;
  typedef logic [DATA_W-1:0] word_t;

  // Link value that terminates the list; also the head of an empty list.
  localparam idx_t LIST_END = idx_t'(NUM_PAGES);

  typedef enum logic [1:0] {
    FUNC_INIT  = 2'd0,
    FUNC_ALLOC = 2'd1,
    FUNC_FREE  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    REG_START = 1'b0,
    REG_END   = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INIT,
    S_ALLOC
  } state_e;

  typedef struct packed {
    word_t region_start;
    word_t region_end;
  } cfg_t;

  typedef struct packed {
    logic      we;
    ram_addr_t waddr;
    idx_t      wdata;
    logic      re;
    ram_addr_t raddr;
  } mem_req_t;

endpackage

/* hdl/page_free_list_allocator_top.sv */
// Channel  Direction  Handshake              Words
// in       input      in_valid_i/in_ready_o   func_i, page_address_i
// out      output     out_valid_o/out_ready_i granted_address_o, status_o
// cfg      input      APB psel/penable       region_start (0x0), region_end (0x4)
//
// A free, an unused code or an allocate on an empty list is answered from the idle state.
// An allocate passes through S_ALLOC, where the registered read of the link memory returns.
// A rebuild walks its n pages in S_INIT and writes one link per cycle.
// Reset empties the list; the link memory has no clearing pass and holds
// garbage until a rebuild writes it. A word is taken only while the output
// register is empty or being drained, so a stalled output stalls the input.
module page_free_list_allocator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pfla_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    func_i,
  input  logic [31:0]                   page_address_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [31:0]                   granted_address_o,
  output logic [1:0]                    status_o
);

  pfla_pkg::cfg_t     cfg;
  pfla_pkg::mem_req_t mem_req;
  pfla_pkg::idx_t     mem_rdata;

  pfla_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pfla_link_ram u_link_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  pfla_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .func_i            (func_i),
    .page_address_i    (page_address_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .granted_address_o (granted_address_o),
    .status_o          (status_o),
    .mem_req_o         (mem_req),
    .mem_rdata_i       (mem_rdata)
  );

  // An accepted word never lands on top of a result that is still held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> (!out_valid_o || out_ready_i))
    else $error("input accepted while output register is blocked");

  // Only a successful allocate carries a nonzero address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != pfla_pkg::ST_OK) |-> (granted_address_o == '0))
    else $error("failed request returned an address");

  // Granted addresses are page aligned.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (granted_address_o[pfla_pkg::PAGE_SHIFT-1:0] == '0))
    else $error("granted address not page aligned");

  // The link memory is never read and written in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.we && mem_req.re))
    else $error("link memory read and write collide");

endmodule

/* hdl/pfla_link_ram.sv */
module pfla_link_ram (
  input  logic              clk_i,
  input  pfla_pkg::mem_req_t req_i,
  output pfla_pkg::idx_t    rdata_o
);

  pfla_pkg::idx_t mem [pfla_pkg::NUM_PAGES];
  pfla_pkg::idx_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/pfla_regs.sv */
module pfla_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pfla_pkg::PADDR_W-1:0]  paddr,
  input  pfla_pkg::word_t               pwdata,
  output pfla_pkg::word_t               prdata,
  output logic                          pready,
  output pfla_pkg::cfg_t                cfg_o
);

  pfla_pkg::word_t start_q, start_d;
  pfla_pkg::word_t end_q, end_d;
  pfla_pkg::reg_e  sel;
  logic            wr_en;

  assign pready = 1'b1;
  assign sel    = pfla_pkg::reg_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    start_d = start_q;
    end_d   = end_q;
    if (wr_en) begin
      unique case (sel)
        pfla_pkg::REG_START: start_d = pwdata;
        pfla_pkg::REG_END:   end_d   = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      pfla_pkg::REG_START: prdata = start_q;
      pfla_pkg::REG_END:   prdata = end_q;
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      end_q   <= '0;
    end else begin
      start_q <= start_d;
      end_q   <= end_d;
    end
  end

  assign cfg_o.region_start = start_q;
  assign cfg_o.region_end   = end_q;

endmodule

/* hdl/pfla_ctrl.sv */
module pfla_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pfla_pkg::cfg_t       cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           func_i,
  input  pfla_pkg::word_t      page_address_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pfla_pkg::word_t      granted_address_o,
  output logic [1:0]           status_o,
  output pfla_pkg::mem_req_t   mem_req_o,
  input  pfla_pkg::idx_t       mem_rdata_i
);

  localparam int unsigned LOW_W      = pfla_pkg::PAGE_NUM_W + 1;
  localparam int unsigned DATA_W_EXT = pfla_pkg::DATA_W + 1;

  pfla_pkg::state_e    state_q, state_d;
  pfla_pkg::idx_t      head_q, head_d;
  pfla_pkg::idx_t      count_q, count_d;
  pfla_pkg::word_t     base_q, base_d;
  pfla_pkg::ram_addr_t walk_q, walk_d;
  logic                out_valid_q, out_valid_d;
  pfla_pkg::word_t     gnt_q, gnt_d;
  pfla_pkg::status_e   status_q, status_d;

  logic                accept;
  logic                walk_last;
  logic                res_load;
  pfla_pkg::word_t     res_gnt;
  pfla_pkg::status_e   res_status;

  // Region rounding for a rebuild, in page numbers.
  logic [DATA_W_EXT-1:0] start_up;
  logic [LOW_W-1:0]      lo_page;
  logic [LOW_W-1:0]      hi_page;
  logic [LOW_W-1:0]      span;
  pfla_pkg::idx_t        init_n;

  // Range check and index for a free.
  logic [DATA_W_EXT-1:0] region_top;
  pfla_pkg::word_t       free_off;
  logic [pfla_pkg::PAGE_NUM_W-1:0] free_page;
  logic                  free_ok;

  assign accept = in_valid_i && in_ready_o;

  assign start_up = {1'b0, cfg_i.region_start} + DATA_W_EXT'(pfla_pkg::PAGE_BYTES - 1);
  assign lo_page  = start_up[pfla_pkg::DATA_W:pfla_pkg::PAGE_SHIFT];
  assign hi_page  = {1'b0, cfg_i.region_end[pfla_pkg::DATA_W-1:pfla_pkg::PAGE_SHIFT]};
  assign span     = hi_page - lo_page;

  always_comb begin
    if (hi_page <= lo_page) begin
      init_n = '0;
    end else if (span > LOW_W'(pfla_pkg::NUM_PAGES)) begin
      init_n = pfla_pkg::LIST_END;
    end else begin
      init_n = span[pfla_pkg::IDX_W-1:0];
    end
  end

  assign region_top = {1'b0, base_q} + (DATA_W_EXT'(count_q) << pfla_pkg::PAGE_SHIFT);
  assign free_off   = page_address_i - base_q;
  assign free_page  = free_off[pfla_pkg::DATA_W-1:pfla_pkg::PAGE_SHIFT];
  assign free_ok    = (count_q != '0) && (page_address_i >= base_q)
                   && ({1'b0, page_address_i} < region_top)
                   && (free_page < pfla_pkg::PAGE_NUM_W'(pfla_pkg::NUM_PAGES));

  assign walk_last = ({1'b0, walk_q} == count_q - 1'b1);

  // A new word is taken only when the output register is free, so a result
  // produced later by a rebuild or an allocate always finds room.
  assign in_ready_o = (state_q == pfla_pkg::S_IDLE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfla_pkg::S_IDLE: begin
        if (accept) begin
          if (func_i == pfla_pkg::FUNC_INIT && init_n != '0) begin
            state_d = pfla_pkg::S_INIT;
          end else if (func_i == pfla_pkg::FUNC_ALLOC && head_q < pfla_pkg::LIST_END
                       && head_q < count_q) begin
            state_d = pfla_pkg::S_ALLOC;
          end
        end
      end
      pfla_pkg::S_INIT: begin
        if (walk_last) begin
          state_d = pfla_pkg::S_IDLE;
        end
      end
      pfla_pkg::S_ALLOC: state_d = pfla_pkg::S_IDLE;
      default:           state_d = pfla_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    base_d     = base_q;
    walk_d     = walk_q;
    res_load   = 1'b0;
    res_gnt    = '0;
    res_status = pfla_pkg::ST_OK;
    mem_req_o  = '0;

    unique case (state_q)
      pfla_pkg::S_IDLE: begin
        if (accept) begin
          unique case (func_i)
            pfla_pkg::FUNC_INIT: begin
              count_d = init_n;
              base_d  = (init_n != '0)
                      ? {lo_page[pfla_pkg::PAGE_NUM_W-1:0], pfla_pkg::PAGE_SHIFT'(0)}
                      : '0;
              head_d  = pfla_pkg::LIST_END;
              walk_d  = '0;
              res_load = (init_n == '0);
            end
            pfla_pkg::FUNC_ALLOC: begin
              if (head_q < pfla_pkg::LIST_END && head_q < count_q) begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = head_q[pfla_pkg::RAM_AW-1:0];
              end else begin
                res_load   = 1'b1;
                res_status = pfla_pkg::ST_EMPTY;
              end
            end
            pfla_pkg::FUNC_FREE: begin
              res_load = 1'b1;
              if (free_ok) begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = free_page[pfla_pkg::RAM_AW-1:0];
                mem_req_o.wdata = head_q;
                head_d          = {1'b0, free_page[pfla_pkg::RAM_AW-1:0]};
              end else begin
                res_status = pfla_pkg::ST_OUTSIDE;
              end
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      pfla_pkg::S_INIT: begin
        // Page walk_q links to the page below it; page zero ends the list.
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = walk_q;
        mem_req_o.wdata = (walk_q == '0) ? pfla_pkg::LIST_END : ({1'b0, walk_q} - 1'b1);
        head_d          = {1'b0, walk_q};
        walk_d          = walk_q + 1'b1;
        res_load        = walk_last;
      end
      pfla_pkg::S_ALLOC: begin
        res_load = 1'b1;
        res_gnt  = base_q + (pfla_pkg::DATA_W'(head_q[pfla_pkg::RAM_AW-1:0])
                             << pfla_pkg::PAGE_SHIFT);
        head_d   = (mem_rdata_i > pfla_pkg::LIST_END) ? pfla_pkg::LIST_END : mem_rdata_i;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    gnt_d       = gnt_q;
    status_d    = status_q;
    if (res_load) begin
      out_valid_d = 1'b1;
      gnt_d       = res_gnt;
      status_d    = res_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfla_pkg::S_IDLE;
      head_q      <= pfla_pkg::LIST_END;
      count_q     <= '0;
      base_q      <= '0;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      base_q      <= base_d;
      walk_q      <= walk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gnt_q    <= gnt_d;
    status_q <= status_d;
  end

  assign out_valid_o       = out_valid_q;
  assign granted_address_o = gnt_q;
  assign status_o          = status_q;

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
  localparam int unsigned DRAIN_CYCLES = pfla_pkg::NUM_PAGES + 16;
  localparam int unsigned NUM_PHASES   = 14;
  localparam int unsigned PHASE_WORDS  = 104;

  typedef struct {
    pfla_pkg::word_t   granted;
    pfla_pkg::status_e status;
  } grant_t;

  class alloc_scoreboard;
    pfla_pkg::word_t region_start;
    pfla_pkg::word_t region_end;
    pfla_pkg::idx_t  link [pfla_pkg::NUM_PAGES];
    pfla_pkg::idx_t  head;
    pfla_pkg::idx_t  count;
    pfla_pkg::word_t base;
    grant_t          grants_due [$];
    int              errors;

    function new();
      region_start = '0;
      region_end   = '0;
      head         = pfla_pkg::LIST_END;
      count        = '0;
      base         = '0;
      errors       = 0;
    endfunction

    function void report(string what);
      errors++;
      $display("[%0t] %s", $time, what);
    endfunction

    // The walk pushes ascending pages, so the highest page ends up at the head.
    function void rebuild();
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned n;
      lo = region_start;
      lo = ((lo + pfla_pkg::PAGE_BYTES - 1) / pfla_pkg::PAGE_BYTES) * pfla_pkg::PAGE_BYTES;
      hi = region_end;
      hi = (hi / pfla_pkg::PAGE_BYTES) * pfla_pkg::PAGE_BYTES;
      n  = (hi > lo) ? (hi - lo) / pfla_pkg::PAGE_BYTES : 0;
      if (n > pfla_pkg::NUM_PAGES) n = pfla_pkg::NUM_PAGES;
      count = pfla_pkg::idx_t'(n);
      base  = (n != 0) ? pfla_pkg::word_t'(lo) : '0;
      head  = pfla_pkg::LIST_END;
      for (int i = 0; i < n; i++) begin
        link[i] = head;
        head    = pfla_pkg::idx_t'(i);
      end
    endfunction

    function grant_t note_request(logic [1:0] func, pfla_pkg::word_t addr);
      grant_t          g;
      longint unsigned top;
      int unsigned     idx;
      g.granted = '0;
      g.status  = pfla_pkg::ST_OK;
      case (func)
        pfla_pkg::FUNC_INIT: rebuild();
        pfla_pkg::FUNC_ALLOC: begin
          if (head >= pfla_pkg::LIST_END || head >= count) begin
            g.status = pfla_pkg::ST_EMPTY;
          end else begin
            g.granted = base + (pfla_pkg::word_t'(head) << pfla_pkg::PAGE_SHIFT);
            head      = link[head];
            if (head > pfla_pkg::LIST_END) head = pfla_pkg::LIST_END;
          end
        end
        pfla_pkg::FUNC_FREE: begin
          top = base;
          top = top + count * pfla_pkg::PAGE_BYTES;
          if (count == 0 || addr < base || addr >= top) begin
            g.status = pfla_pkg::ST_OUTSIDE;
          end else begin
            idx       = (addr - base) >> pfla_pkg::PAGE_SHIFT;
            link[idx] = head;
            head      = pfla_pkg::idx_t'(idx);
          end
        end
        default: ;
      endcase
      grants_due.push_back(g);
      return g;
    endfunction

    function void check_grant(pfla_pkg::word_t granted, logic [1:0] status);
      grant_t g;
      if (grants_due.size() == 0) begin
        report($sformatf("unexpected word: granted %h status %0d", granted, status));
        return;
      end
      g = grants_due.pop_front();
      if (granted !== g.granted)
        report($sformatf("granted %h, want %h", granted, g.granted));
      if (status !== g.status)
        report($sformatf("status %0d, want %0d", status, g.status));
    endfunction
  endclass

  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          psel           = 1'b0;
  logic                          penable        = 1'b0;
  logic                          pwrite         = 1'b0;
  logic [pfla_pkg::PADDR_W-1:0]  paddr          = '0;
  logic [31:0]                   pwdata         = '0;
  logic [31:0]                   prdata;
  logic                          pready;
  logic                          in_valid_i     = 1'b0;
  logic                          in_ready_o;
  logic [1:0]                    func_i         = 2'd0;
  pfla_pkg::word_t               page_address_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i    = 1'b0;
  pfla_pkg::word_t               granted_address_o;
  logic [1:0]                    status_o;

  alloc_scoreboard sb = new();
  pfla_pkg::word_t held [$];
  bit              calm = 1'b0;
  int              stall_left = 0;

  page_free_list_allocator_top u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .func_i            (func_i),
    .page_address_i    (page_address_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .granted_address_o (granted_address_o),
    .status_o          (status_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_grant(granted_address_o, status_o);
    if (stall_left > 0 && !calm) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      stall_left = 0;
      if (!calm && $urandom_range(0, 99) < 20) stall_left = pick_gap();
    end
  end

  task automatic send_word(logic [1:0] func, pfla_pkg::word_t addr);
    grant_t g;
    int     gap;
    in_valid_i     <= 1'b1;
    func_i         <= func;
    page_address_i <= addr;
    do @(posedge clk_i); while (!in_ready_o);
    g = sb.note_request(func, addr);
    if (func == pfla_pkg::FUNC_INIT) held.delete();
    if (func == pfla_pkg::FUNC_ALLOC && g.status == pfla_pkg::ST_OK) held.push_back(g.granted);
    gap = (calm || $urandom_range(0, 99) < 60) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Waits out every pending word plus the longest rebuild walk.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.grants_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_xfer(bit wr, pfla_pkg::reg_e r, pfla_pkg::word_t v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= pfla_pkg::PADDR_W'(int'(r) * 4);
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (!wr && prdata !== v)
      sb.report($sformatf("register %0d reads %h, want %h", r, prdata, v));
  endtask

  task automatic program_region(pfla_pkg::word_t start_addr, pfla_pkg::word_t end_addr);
    apb_xfer(1'b1, pfla_pkg::REG_START, start_addr);
    apb_xfer(1'b1, pfla_pkg::REG_END, end_addr);
    apb_xfer(1'b0, pfla_pkg::REG_START, start_addr);
    apb_xfer(1'b0, pfla_pkg::REG_END, end_addr);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.region_start = start_addr;
    sb.region_end   = end_addr;
  endtask

  // Mostly pages that are out on loan, so the list keeps a well-formed shape.
  function automatic pfla_pkg::word_t pick_free_addr();
    int              r;
    int              i;
    pfla_pkg::word_t a;
    longint unsigned top;
    r   = $urandom_range(0, 99);
    top = sb.base;
    top = top + sb.count * pfla_pkg::PAGE_BYTES;
    if (r < 70 && held.size() != 0) begin
      i = $urandom_range(0, held.size() - 1);
      a = held[i];
      if ($urandom_range(0, 9) != 0) held.delete(i);
      return a | pfla_pkg::word_t'($urandom_range(0, pfla_pkg::PAGE_BYTES - 1));
    end
    if (r < 80 && sb.count != 0)
      return sb.base
             + pfla_pkg::word_t'($urandom_range(0, sb.count - 1)) * pfla_pkg::PAGE_BYTES
             + pfla_pkg::word_t'($urandom_range(0, pfla_pkg::PAGE_BYTES - 1));
    if (r < 85)
      return sb.base - 1 - pfla_pkg::word_t'($urandom_range(0, pfla_pkg::PAGE_BYTES - 1));
    if (r < 90)
      return pfla_pkg::word_t'(top)
             + pfla_pkg::word_t'($urandom_range(0, 2 * pfla_pkg::PAGE_BYTES));
    return $urandom;
  endfunction

  task automatic pick_region(int p, output pfla_pkg::word_t s, output pfla_pkg::word_t e);
    case (p)
      1:  begin s = 32'h0000_0000; e = 32'hFFFF_FFFF; end
      3:  begin s = 32'hFFFF_F001; e = 32'hFFFF_FFFF; end
      5:  begin s = 32'hFFFF_E000; e = 32'hFFFF_FFFF; end
      7:  begin s = 32'hFFFF_FFFF; e = 32'h0000_0000; end
      9:  begin s = 32'h0000_0000; e = 32'h0000_0000; end
      11: begin
        s = $urandom;
        e = s + pfla_pkg::word_t'($urandom_range(1000, 1100)) * pfla_pkg::PAGE_BYTES;
      end
      default: begin
        s = $urandom;
        e = s + pfla_pkg::word_t'($urandom_range(0, 24)) * pfla_pkg::PAGE_BYTES
            + pfla_pkg::word_t'($urandom_range(0, pfla_pkg::PAGE_BYTES - 1));
      end
    endcase
  endtask

  initial begin
    pfla_pkg::word_t s;
    pfla_pkg::word_t e;
    int              r;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Before any rebuild the list is empty and no address is inside the region.
    send_word(pfla_pkg::FUNC_ALLOC, 32'h0);
    send_word(pfla_pkg::FUNC_FREE, 32'h0);
    send_word(FUNC_UNUSED, 32'hFFFF_FFFF);
    send_word(pfla_pkg::FUNC_INIT, 32'h0);
    send_word(pfla_pkg::FUNC_ALLOC, 32'hFFFF_FFFF);
    settle();

    // Unaligned bounds give three pages from 0x2000 up to 0x5000.
    program_region(32'h0000_1234, 32'h0000_5FFF);
    send_word(pfla_pkg::FUNC_INIT, 32'h0);
    repeat (4) send_word(pfla_pkg::FUNC_ALLOC, 32'h0);
    send_word(pfla_pkg::FUNC_FREE, 32'h0000_3ABC);
    send_word(pfla_pkg::FUNC_FREE, 32'h0000_1FFF);
    send_word(pfla_pkg::FUNC_FREE, 32'h0000_5000);
    send_word(pfla_pkg::FUNC_FREE, 32'h0000_2000);
    send_word(pfla_pkg::FUNC_FREE, 32'h0000_2FFF);
    repeat (3) send_word(pfla_pkg::FUNC_ALLOC, 32'h0);
    send_word(FUNC_UNUSED, 32'h0);
    settle();

    // New bounds stay latent until the next rebuild.
    program_region(32'h0000_0000, 32'h0000_3000);
    send_word(pfla_pkg::FUNC_FREE, 32'h0000_5000);
    send_word(pfla_pkg::FUNC_FREE, 32'h0000_4000);
    send_word(pfla_pkg::FUNC_ALLOC, 32'h0);
    send_word(pfla_pkg::FUNC_INIT, 32'h0);
    send_word(pfla_pkg::FUNC_ALLOC, 32'h0);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      calm = (p % 5 == 4);
      pick_region(p, s, e);
      program_region(s, e);
      if ($urandom_range(0, 99) < 85) send_word(pfla_pkg::FUNC_INIT, $urandom);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 3)       send_word(pfla_pkg::FUNC_INIT, $urandom);
        else if (r < 6)  send_word(FUNC_UNUSED, $urandom);
        else if (r < 52) send_word(pfla_pkg::FUNC_ALLOC, $urandom);
        else             send_word(pfla_pkg::FUNC_FREE, pick_free_addr());
      end
      settle();
    end

    if (sb.errors == 0) $display("page_free_list_allocator_top: match");
    else $display("page_free_list_allocator_top: mismatch");
    $finish;
  end

  initial begin
    #20ms;
    $display("page_free_list_allocator_top: mismatch");
    $finish;
  end

endmodule
